// ===== design/gdd_pkg.sv =====
// Shared types and constants of the gesture direction decoder.
`timescale 1ns / 1ps
`default_nettype none
package gdd_pkg;

   localparam int LEVEL_W    = 8;
   localparam int CFG_W      = 8;
   localparam int DIVIDEND_W = 15;
   localparam int DIVISOR_W  = 9;
   localparam int RATIO_W    = 8;
   localparam int SUM_W      = 16;
   localparam int DELTA_W    = 9;
   localparam int COUNT_W    = 8;
   localparam int MOTION_W   = 3;
   localparam int PROX_W     = 2;
   localparam int VOTE_W     = 2;
   localparam int ADDR_W     = 5;
   localparam int DATA_W     = 32;
   localparam int RATIO_SCALE = 100;

   localparam logic [MOTION_W-1:0] MOTION_NONE  = 3'd0;
   localparam logic [MOTION_W-1:0] MOTION_LEFT  = 3'd1;
   localparam logic [MOTION_W-1:0] MOTION_RIGHT = 3'd2;
   localparam logic [MOTION_W-1:0] MOTION_UP    = 3'd3;
   localparam logic [MOTION_W-1:0] MOTION_DOWN  = 3'd4;
   localparam logic [MOTION_W-1:0] MOTION_NEAR  = 3'd5;
   localparam logic [MOTION_W-1:0] MOTION_FAR   = 3'd6;

   localparam logic [PROX_W-1:0] PROX_NONE = 2'd0;
   localparam logic [PROX_W-1:0] PROX_NEAR = 2'd1;
   localparam logic [PROX_W-1:0] PROX_FAR  = 2'd2;

   localparam logic [VOTE_W-1:0] VOTE_ZERO = 2'b00;
   localparam logic [VOTE_W-1:0] VOTE_POS  = 2'b01;
   localparam logic [VOTE_W-1:0] VOTE_NEG  = 2'b11;

   localparam logic [2:0] REG_CHANNEL_THRESHOLD     = 3'd0;
   localparam logic [2:0] REG_DIRECTION_SENSITIVITY = 3'd1;
   localparam logic [2:0] REG_STILL_SENSITIVITY     = 3'd2;
   localparam logic [2:0] REG_NEAR_COUNT_LIMIT      = 3'd3;
   localparam logic [2:0] REG_FAR_COUNT_LIMIT       = 3'd4;

   localparam logic [CFG_W-1:0] RST_CHANNEL_THRESHOLD     = 8'd10;
   localparam logic [CFG_W-1:0] RST_DIRECTION_SENSITIVITY = 8'd50;
   localparam logic [CFG_W-1:0] RST_STILL_SENSITIVITY     = 8'd20;
   localparam logic [CFG_W-1:0] RST_NEAR_COUNT_LIMIT      = 8'd10;
   localparam logic [CFG_W-1:0] RST_FAR_COUNT_LIMIT       = 8'd2;

   typedef struct packed {
      logic                  start;
      logic                  negate;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                      done;
      logic signed [RATIO_W-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

// ===== design/gdd_div.sv =====
// Restoring divider, one quotient bit per cycle, truncating signed result.
`timescale 1ns / 1ps
`default_nettype none
module gdd_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire gdd_pkg::div_req_type div_req,
   output gdd_pkg::div_rsp_type      div_rsp
);
   import gdd_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  den_ff, den_in;
   logic                  neg_ff, neg_in;

   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    trial;
   logic                  ge;
   logic [RATIO_W-1:0]    quo_mag;

   assign shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign ge      = shifted >= {1'b0, den_ff};
   assign trial   = shifted - {1'b0, den_ff};
   assign quo_mag = quo_ff[RATIO_W-1:0];

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? $signed(RATIO_W'(0) - quo_mag) : $signed(quo_mag);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         rem_in  = '0;
         quo_in  = div_req.dividend;
         den_in  = div_req.divisor;
         neg_in  = div_req.negate;
      end else if (busy_ff) begin
         rem_in = ge ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

endmodule
`default_nettype wire

// ===== design/gesture_direction_decoder.sv =====
// Top level: batch tracking, ratio sequencing, vote and proximity update, decode.
// Dataset item without batch close: stays idle, ready unless a response waits.
// Batch close with a qualifying dataset: busy through four 15-step divisions on
// the shared divider, then through the S_SUM and S_PROX update states.
// End of gesture: the result is registered from the transfer itself.
// Synchronous reset restores register defaults and state but ratios and motion.
`timescale 1ns / 1ps
`default_nettype none
module gesture_direction_decoder (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_action,
   input  wire logic [gdd_pkg::LEVEL_W-1:0]   req_up_level,
   input  wire logic [gdd_pkg::LEVEL_W-1:0]   req_down_level,
   input  wire logic [gdd_pkg::LEVEL_W-1:0]   req_left_level,
   input  wire logic [gdd_pkg::LEVEL_W-1:0]   req_right_level,
   input  wire logic                          req_batch_end,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [gdd_pkg::MOTION_W-1:0]       rsp_motion,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [gdd_pkg::ADDR_W-1:0]    csr_paddr,
   input  wire logic [gdd_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [gdd_pkg::DATA_W-1:0]         csr_prdata,
   output logic                               csr_pready
);
   import gdd_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOAD = 3'd1;
   localparam logic [2:0] S_WAIT = 3'd2;
   localparam logic [2:0] S_SUM  = 3'd3;
   localparam logic [2:0] S_PROX = 3'd4;

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                 input logic [DELTA_W-1:0] d);
      logic [SUM_W:0] ext;
      ext = {s[SUM_W-1], s} + {{(SUM_W+1-DELTA_W){d[DELTA_W-1]}}, d};
      if (ext[SUM_W] != ext[SUM_W-1])
         return ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      return ext[SUM_W-1:0];
   endfunction

   function automatic logic [VOTE_W-1:0] vote_of(input logic [SUM_W-1:0] s,
                                                  input logic [CFG_W-1:0] sens);
      logic signed [SUM_W:0] sv;
      logic signed [SUM_W:0] lim;
      sv  = $signed({s[SUM_W-1], s});
      lim = $signed({{(SUM_W+1-CFG_W){1'b0}}, sens});
      if (sv >= lim) return VOTE_POS;
      if (sv <= -lim) return VOTE_NEG;
      return VOTE_ZERO;
   endfunction

   function automatic logic [COUNT_W-1:0] inc_sat(input logic [COUNT_W-1:0] c);
      return (c == {COUNT_W{1'b1}}) ? c : c + 1'b1;
   endfunction

   function automatic logic [SUM_W:0] sum_mag(input logic [SUM_W-1:0] s);
      return s[SUM_W-1] ? (SUM_W+1)'(0) - {1'b1, s} : {1'b0, s};
   endfunction

   function automatic logic [RATIO_W-1:0] delta_mag(input logic [DELTA_W-1:0] d);
      logic [DELTA_W-1:0] m;
      m = d[DELTA_W-1] ? DELTA_W'(0) - d : d;
      return m[RATIO_W-1:0];
   endfunction

   // configuration
   logic [CFG_W-1:0] threshold_ff, dir_sens_ff, still_sens_ff, near_limit_ff, far_limit_ff;
   logic             csr_write;
   logic [2:0]       csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= RST_CHANNEL_THRESHOLD;
         dir_sens_ff   <= RST_DIRECTION_SENSITIVITY;
         still_sens_ff <= RST_STILL_SENSITIVITY;
         near_limit_ff <= RST_NEAR_COUNT_LIMIT;
         far_limit_ff  <= RST_FAR_COUNT_LIMIT;
      end else if (csr_write) begin
         case (csr_index)
            REG_CHANNEL_THRESHOLD:     threshold_ff  <= csr_pwdata[CFG_W-1:0];
            REG_DIRECTION_SENSITIVITY: dir_sens_ff   <= csr_pwdata[CFG_W-1:0];
            REG_STILL_SENSITIVITY:     still_sens_ff <= csr_pwdata[CFG_W-1:0];
            REG_NEAR_COUNT_LIMIT:      near_limit_ff <= csr_pwdata[CFG_W-1:0];
            REG_FAR_COUNT_LIMIT:       far_limit_ff  <= csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_CHANNEL_THRESHOLD:     csr_prdata = DATA_W'(threshold_ff);
         REG_DIRECTION_SENSITIVITY: csr_prdata = DATA_W'(dir_sens_ff);
         REG_STILL_SENSITIVITY:     csr_prdata = DATA_W'(still_sens_ff);
         REG_NEAR_COUNT_LIMIT:      csr_prdata = DATA_W'(near_limit_ff);
         REG_FAR_COUNT_LIMIT:       csr_prdata = DATA_W'(far_limit_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // state
   logic [2:0]              state_ff, state_in;
   logic [1:0]              idx_ff, idx_in;
   logic                    found_ff, found_in;
   logic [4*LEVEL_W-1:0]    first_ff, first_in;
   logic [4*LEVEL_W-1:0]    last_ff, last_in;
   logic [SUM_W-1:0]        ud_sum_ff, ud_sum_in, lr_sum_ff, lr_sum_in;
   logic [VOTE_W-1:0]       ud_vote_ff, ud_vote_in, lr_vote_ff, lr_vote_in;
   logic [COUNT_W-1:0]      near_ff, near_in, far_ff, far_in;
   logic [PROX_W-1:0]       prox_ff, prox_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [MOTION_W-1:0]     rsp_motion_ff, rsp_motion_in;
   logic signed [RATIO_W-1:0] ratio_ff [4];

   logic                    req_fire, rsp_fire, qualify;
   logic [4*LEVEL_W-1:0]    packed_in;
   logic [4*LEVEL_W-1:0]    sample;
   logic [LEVEL_W-1:0]      op_a, op_b, op_mag;
   logic [DELTA_W-1:0]      ud_d, lr_d;
   logic                    is_still, zero;
   logic [MOTION_W-1:0]     motion;
   logic                    ud_wins;
   div_req_type             div_req;
   div_rsp_type             div_rsp;

   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_motion = rsp_motion_ff;

   assign qualify   = (req_up_level > threshold_ff) && (req_down_level > threshold_ff) &&
                      (req_left_level > threshold_ff) && (req_right_level > threshold_ff);
   assign packed_in = {req_up_level, req_down_level, req_left_level, req_right_level};

   // divider operands: first ud, first lr, last ud, last lr
   assign sample = idx_ff[1] ? last_ff : first_ff;
   assign op_a   = idx_ff[0] ? sample[2*LEVEL_W-1:LEVEL_W]   : sample[4*LEVEL_W-1:3*LEVEL_W];
   assign op_b   = idx_ff[0] ? sample[LEVEL_W-1:0]           : sample[3*LEVEL_W-1:2*LEVEL_W];
   assign op_mag = (op_a >= op_b) ? op_a - op_b : op_b - op_a;

   assign div_req.start    = (state_ff == S_LOAD);
   assign div_req.negate   = op_a < op_b;
   assign div_req.dividend = DIVIDEND_W'(op_mag) * DIVIDEND_W'(RATIO_SCALE);
   assign div_req.divisor  = {1'b0, op_a} + {1'b0, op_b};

   gdd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (state_ff == S_WAIT && div_rsp.done) begin
         ratio_ff[idx_ff] <= div_rsp.quotient;
      end
   end

   assign ud_d = {ratio_ff[2][RATIO_W-1], ratio_ff[2]} - {ratio_ff[0][RATIO_W-1], ratio_ff[0]};
   assign lr_d = {ratio_ff[3][RATIO_W-1], ratio_ff[3]} - {ratio_ff[1][RATIO_W-1], ratio_ff[1]};
   assign is_still = (delta_mag(ud_d) < still_sens_ff) && (delta_mag(lr_d) < still_sens_ff);
   assign zero     = (ud_d == '0) && (lr_d == '0);

   // gesture decode
   assign ud_wins = sum_mag(ud_sum_ff) > sum_mag(lr_sum_ff);

   always_comb begin
      if (prox_ff == PROX_NEAR) begin
         motion = MOTION_NEAR;
      end else if (prox_ff == PROX_FAR) begin
         motion = MOTION_FAR;
      end else if (ud_vote_ff == VOTE_ZERO) begin
         if (lr_vote_ff == VOTE_POS)      motion = MOTION_RIGHT;
         else if (lr_vote_ff == VOTE_NEG) motion = MOTION_LEFT;
         else                             motion = MOTION_NONE;
      end else if (lr_vote_ff == VOTE_ZERO || ud_wins) begin
         motion = (ud_vote_ff == VOTE_NEG) ? MOTION_UP : MOTION_DOWN;
      end else begin
         motion = (lr_vote_ff == VOTE_POS) ? MOTION_RIGHT : MOTION_LEFT;
      end
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      ud_sum_in     = ud_sum_ff;
      lr_sum_in     = lr_sum_ff;
      ud_vote_in    = ud_vote_ff;
      lr_vote_in    = lr_vote_ff;
      near_in       = near_ff;
      far_in        = far_ff;
      prox_in       = prox_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_fire;
      rsp_motion_in = rsp_motion_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_action) begin
                  rsp_valid_in  = 1'b1;
                  rsp_motion_in = motion;
                  ud_sum_in     = '0;
                  lr_sum_in     = '0;
                  ud_vote_in    = VOTE_ZERO;
                  lr_vote_in    = VOTE_ZERO;
                  near_in       = '0;
                  far_in        = '0;
                  prox_in       = PROX_NONE;
                  found_in      = 1'b0;
                  first_in      = '0;
                  last_in       = '0;
               end else begin
                  if (qualify) begin
                     if (!found_ff) first_in = packed_in;
                     found_in = 1'b1;
                     last_in  = packed_in;
                  end
                  if (req_batch_end && (found_ff || qualify)) begin
                     idx_in   = 2'd0;
                     state_in = S_LOAD;
                  end
               end
            end
         end
         S_LOAD: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (div_rsp.done) begin
               if (idx_ff == 2'd3) begin
                  state_in = S_SUM;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_LOAD;
               end
            end
         end
         S_SUM: begin
            ud_sum_in  = sat_add(ud_sum_ff, ud_d);
            lr_sum_in  = sat_add(lr_sum_ff, lr_d);
            ud_vote_in = vote_of(ud_sum_in, dir_sens_ff);
            lr_vote_in = vote_of(lr_sum_in, dir_sens_ff);
            state_in   = S_PROX;
         end
         S_PROX: begin
            if (ud_vote_ff == VOTE_ZERO && lr_vote_ff == VOTE_ZERO) begin
               if (is_still) begin
                  if (zero) near_in = inc_sat(near_ff);
                  else      far_in  = inc_sat(far_ff);
                  if (near_in >= near_limit_ff && far_in >= far_limit_ff) begin
                     if (zero)                              prox_in = PROX_NEAR;
                     else if (ud_d != '0 && lr_d != '0)     prox_in = PROX_FAR;
                  end
               end
            end else if (is_still) begin
               if (zero) near_in = inc_sat(near_ff);
               if (near_in >= near_limit_ff) begin
                  ud_vote_in = VOTE_ZERO;
                  lr_vote_in = VOTE_ZERO;
                  ud_sum_in  = '0;
                  lr_sum_in  = '0;
               end
            end
            found_in = 1'b0;
            first_in = '0;
            last_in  = '0;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= 2'd0;
         found_ff     <= 1'b0;
         first_ff     <= '0;
         last_ff      <= '0;
         ud_sum_ff    <= '0;
         lr_sum_ff    <= '0;
         ud_vote_ff   <= VOTE_ZERO;
         lr_vote_ff   <= VOTE_ZERO;
         near_ff      <= '0;
         far_ff       <= '0;
         prox_ff      <= PROX_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         found_ff     <= found_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         ud_sum_ff    <= ud_sum_in;
         lr_sum_ff    <= lr_sum_in;
         ud_vote_ff   <= ud_vote_in;
         lr_vote_ff   <= lr_vote_in;
         near_ff      <= near_in;
         far_ff       <= far_in;
         prox_ff      <= prox_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_motion_ff <= rsp_motion_in;
   end

endmodule
`default_nettype wire
